### sv/i2cm_pkg.sv
// Shared types and constants of the open-drain I2C byte master.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned TICK_W      = 8;
  localparam int unsigned PHASE_W     = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [TICK_W-1:0]  PHASE_TICKS_RESET = 8'd8;
  localparam logic [PHASE_W-1:0] WRITE_PHASES      = 5'd27;
  localparam logic [PHASE_W-1:0] READ_PHASES       = 5'd21;
  localparam logic [PHASE_W-1:0] EDGE_PHASES       = 5'd3;
  localparam logic [PHASE_W-1:0] WRITE_BIT_PHASES  = 5'd24;
  localparam logic [PHASE_W-1:0] WRITE_ACK_SDA     = 5'd24;
  localparam logic [PHASE_W-1:0] WRITE_ACK_SCL     = 5'd25;
  localparam logic [PHASE_W-1:0] READ_LAST_BIT     = 5'd16;
  localparam logic [PHASE_W-1:0] READ_ACK_SDA      = 5'd17;
  localparam logic [PHASE_W-1:0] READ_ACK_SCL_HI   = 5'd18;
  localparam logic [PHASE_W-1:0] READ_ACK_SCL_LO   = 5'd19;

  // word index of the phase_ticks register (byte address bit 2)
  localparam logic CFG_IDX_PHASE_TICKS = 1'b0;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SUB_DATA   = 2'd0,
    SUB_SCL_HI = 2'd1,
    SUB_SCL_LO = 2'd2
  } bit_sub_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BYTE_W-1:0] write_data;
    logic              last_read;
    logic              sda_in;
  } in_t;

  typedef struct packed {
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic              acked;
    logic [BYTE_W-1:0] read_byte;
    logic              rejected;
  } out_t;

  // classified tick as handed from the front to the sequencer
  typedef struct packed {
    op_t               cmd;
    logic [BYTE_W-1:0] write_data;
    logic              last_read;
    logic              sda_in;
  } seq_item_t;

endpackage
`default_nettype wire

### sv/i2c_open_drain_byte_master.sv
// Top level of the open-drain I2C byte master: queues, sequencer and register port.
// Each accepted item is one bus tick and yields exactly one result. The block takes
// one item per clock and delivers one result per clock when neither side stalls; an
// item waits in the input queue until the phase sequencer steps it into the result
// queue, whose head shows on the result port. Both queues are two deep, so either
// side may stall without stopping the other at once. phase_ticks (address 0, reset
// 8, 0 acts as 1) sets how many ticks each line phase lasts; write it only while no
// transfer is in flight.
`default_nettype none
module i2c_open_drain_byte_master (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire i2cm_pkg::in_t                      item,
  output logic                                    empty,
  input  wire logic                               pop,
  output i2cm_pkg::out_t                          result,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [i2cm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  logic [7:0]          phase_ticks;
  logic                fvalid;
  logic                take;
  i2cm_pkg::seq_item_t fitem;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == i2cm_pkg::CFG_IDX_PHASE_TICKS)) begin
      phase_ticks <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == i2cm_pkg::CFG_IDX_PHASE_TICKS) ?
                  {24'd0, phase_ticks} : '0;

  i2cm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .fvalid (fvalid),
    .fitem  (fitem),
    .take   (take)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .fvalid      (fvalid),
    .fitem       (fitem),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule
`default_nettype wire

### sv/i2cm_front.sv
// Front end: accepts ticks, classifies the command kind and queues them.
`default_nettype none
module i2cm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire i2cm_pkg::in_t     item,
  output logic                   fvalid,
  output i2cm_pkg::seq_item_t    fitem,
  input  wire logic              take
);

  i2cm_pkg::seq_item_t q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  i2cm_pkg::seq_item_t classified;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    classified.write_data = item.write_data;
    classified.last_read  = item.last_read;
    classified.sda_in     = item.sda_in;
    unique case (item.kind)
      i2cm_pkg::OP_START: classified.cmd = i2cm_pkg::OP_START;
      i2cm_pkg::OP_STOP:  classified.cmd = i2cm_pkg::OP_STOP;
      i2cm_pkg::OP_WRITE: classified.cmd = i2cm_pkg::OP_WRITE;
      i2cm_pkg::OP_READ:  classified.cmd = i2cm_pkg::OP_READ;
      default:            classified.cmd = i2cm_pkg::OP_IDLE;  // plain tick and unused codes
    endcase
  end

  assign full    = (count == 2'd2);
  assign fvalid  = (count != 2'd0);
  assign fitem   = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = take && fvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/i2cm_back.sv
// Back end: line phase sequencer, one tick per step, with a result queue.
`default_nettype none
module i2cm_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            phase_ticks,
  input  wire logic                  fvalid,
  input  wire i2cm_pkg::seq_item_t   fitem,
  output logic                       take,
  output logic                       empty,
  input  wire logic                  pop,
  output i2cm_pkg::out_t             result
);

  i2cm_pkg::op_t     operation, operation_next;
  logic [4:0]        phase_index, phase_index_next;
  i2cm_pkg::bit_sub_t bit_sub, bit_sub_next;
  logic [7:0]        tick_count, tick_count_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic              ack_seen, ack_seen_next;
  logic              scl_drive, scl_drive_next;
  logic              sda_drive, sda_drive_next;

  logic [7:0]        len;
  logic [4:0]        total;
  logic [4:0]        phase_inc;
  logic              phase_end;
  logic              last_phase;
  logic              enter;
  logic              step;
  i2cm_pkg::out_t    res;

  i2cm_pkg::out_t    oq [2];
  logic              owr, ord;
  logic [1:0]        ocount;
  logic              opop;

  assign len       = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign phase_inc = phase_index + 5'd1;
  assign phase_end = (tick_count >= len);

  always_comb begin
    priority case (operation)
      i2cm_pkg::OP_WRITE: total = i2cm_pkg::WRITE_PHASES;
      i2cm_pkg::OP_READ:  total = i2cm_pkg::READ_PHASES;
      default:            total = i2cm_pkg::EDGE_PHASES;
    endcase
  end

  assign last_phase = (phase_inc >= total);
  assign step       = fvalid && (ocount != 2'd2);
  assign take       = step;

  // next state: sequencer registers
  always_comb begin
    operation_next   = operation;
    phase_index_next = phase_index;
    bit_sub_next     = bit_sub;
    tick_count_next  = tick_count;
    shift_byte_next  = shift_byte;
    ack_seen_next    = ack_seen;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    enter            = 1'b0;

    if (operation == i2cm_pkg::OP_IDLE) begin
      if (fitem.cmd != i2cm_pkg::OP_IDLE) begin
        operation_next   = fitem.cmd;
        phase_index_next = 5'd0;
        bit_sub_next     = i2cm_pkg::SUB_DATA;
        tick_count_next  = 8'd1;
        if (fitem.cmd == i2cm_pkg::OP_WRITE) begin
          shift_byte_next = fitem.write_data;
          ack_seen_next   = 1'b0;
        end else if (fitem.cmd == i2cm_pkg::OP_READ) begin
          shift_byte_next = 8'd0;
          ack_seen_next   = fitem.last_read;
        end
        enter = 1'b1;
      end
    end else if (phase_end) begin
      if (last_phase) begin
        operation_next   = i2cm_pkg::OP_IDLE;
        phase_index_next = 5'd0;
        tick_count_next  = 8'd0;
      end else begin
        phase_index_next = phase_inc;
        tick_count_next  = 8'd1;
        unique case (bit_sub)
          i2cm_pkg::SUB_DATA:   bit_sub_next = i2cm_pkg::SUB_SCL_HI;
          i2cm_pkg::SUB_SCL_HI: bit_sub_next = i2cm_pkg::SUB_SCL_LO;
          default:              bit_sub_next = i2cm_pkg::SUB_DATA;
        endcase
        enter = 1'b1;
      end
    end else begin
      tick_count_next = tick_count + 8'd1;
    end

    // line drives on entry to a phase
    if (enter) begin
      unique case (operation_next)
        i2cm_pkg::OP_START: begin
          priority if (phase_index_next == 5'd0) begin
            scl_drive_next = 1'b0;
            sda_drive_next = 1'b0;
          end else if (phase_index_next == 5'd1) begin
            sda_drive_next = 1'b1;
          end else begin
            scl_drive_next = 1'b1;
          end
        end
        i2cm_pkg::OP_STOP: begin
          priority if (phase_index_next == 5'd0) sda_drive_next = 1'b1;
          else if (phase_index_next == 5'd1)     scl_drive_next = 1'b0;
          else                                   sda_drive_next = 1'b0;
        end
        i2cm_pkg::OP_WRITE: begin
          priority if (phase_index_next < i2cm_pkg::WRITE_BIT_PHASES) begin
            unique case (bit_sub_next)
              i2cm_pkg::SUB_DATA:   sda_drive_next = ~shift_byte_next[7];
              i2cm_pkg::SUB_SCL_HI: scl_drive_next = 1'b0;
              default: begin
                scl_drive_next  = 1'b1;
                shift_byte_next = {shift_byte_next[6:0], 1'b0};
              end
            endcase
          end else if (phase_index_next == i2cm_pkg::WRITE_ACK_SDA) begin
            sda_drive_next = 1'b0;
          end else if (phase_index_next == i2cm_pkg::WRITE_ACK_SCL) begin
            scl_drive_next = 1'b0;
          end else begin
            ack_seen_next  = ~fitem.sda_in;
            scl_drive_next = 1'b1;
          end
        end
        i2cm_pkg::OP_READ: begin
          priority if (phase_index_next == 5'd0) begin
            sda_drive_next = 1'b0;
          end else if (phase_index_next <= i2cm_pkg::READ_LAST_BIT) begin
            if (phase_index_next[0]) begin
              scl_drive_next = 1'b0;
            end else begin
              // sample as the clock goes low again
              shift_byte_next = {shift_byte_next[6:0], fitem.sda_in};
              scl_drive_next  = 1'b1;
            end
          end else if (phase_index_next == i2cm_pkg::READ_ACK_SDA) begin
            sda_drive_next = ~ack_seen_next;
          end else if (phase_index_next == i2cm_pkg::READ_ACK_SCL_HI) begin
            scl_drive_next = 1'b0;
          end else if (phase_index_next == i2cm_pkg::READ_ACK_SCL_LO) begin
            scl_drive_next = 1'b1;
          end else begin
            sda_drive_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs: result of this tick
  always_comb begin
    res.scl_pull_low = scl_drive_next;
    res.sda_pull_low = sda_drive_next;
    res.busy_res     = (operation_next != i2cm_pkg::OP_IDLE);
    res.done_res     = 1'b0;
    res.acked        = 1'b0;
    res.read_byte    = 8'd0;
    res.rejected     = 1'b0;
    if (operation != i2cm_pkg::OP_IDLE) begin
      res.rejected = (fitem.cmd != i2cm_pkg::OP_IDLE);
      if (phase_end && last_phase) begin
        res.done_res = 1'b1;
        if (operation == i2cm_pkg::OP_WRITE) res.acked = ack_seen;
        if (operation == i2cm_pkg::OP_READ)  res.read_byte = shift_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= i2cm_pkg::OP_IDLE;
      phase_index <= 5'd0;
      bit_sub     <= i2cm_pkg::SUB_DATA;
      tick_count  <= 8'd0;
      shift_byte  <= 8'd0;
      ack_seen    <= 1'b0;
      scl_drive   <= 1'b0;
      sda_drive   <= 1'b0;
    end else if (step) begin
      operation   <= operation_next;
      phase_index <= phase_index_next;
      bit_sub     <= bit_sub_next;
      tick_count  <= tick_count_next;
      shift_byte  <= shift_byte_next;
      ack_seen    <= ack_seen_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
    end
  end

  // result queue
  assign empty  = (ocount == 2'd0);
  assign result = oq[ord];
  assign opop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (step) begin
      oq[owr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (step) owr <= ~owr;
      if (opop) ord <= ~ord;
      unique case ({step, opop})
        2'b10:   ocount <= ocount + 2'd1;
        2'b01:   ocount <= ocount - 2'd1;
        default: ocount <= ocount;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/i2cm_checker.sv
// Port-level checks of the I2C byte master, bound to the top level.
`default_nettype none
module i2cm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           empty,
  input wire logic           pop,
  input wire i2cm_pkg::out_t result
);

  // reset drops every queued transfer
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // a finished command leaves the controller idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.done_res) |-> !result.busy_res)
    else $error("done and busy on the same result");

  // ack and read data appear only on the done tick
  a_data_on_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.done_res) |-> (!result.acked && (result.read_byte == 8'd0)))
    else $error("ack or read byte outside a done tick");

endmodule

bind i2c_open_drain_byte_master i2cm_checker u_chk (.*);
`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for the open-drain I2C byte master: per-tick line sequence prediction.
`timescale 1ns / 1ps

import i2cm_pkg::*;

class line_scoreboard;
  logic [TICK_W-1:0]  phase_len;
  op_t                op;
  logic [PHASE_W-1:0] phase;
  logic [TICK_W-1:0]  ticks;
  logic [BYTE_W-1:0]  shreg;
  logic               ack_flag;
  logic               scl_dr;
  logic               sda_dr;
  out_t               line_states_due[$];
  int                 errors;

  function new();
    phase_len = PHASE_TICKS_RESET;
    op        = OP_IDLE;
    phase     = '0;
    ticks     = '0;
    shreg     = '0;
    ack_flag  = 1'b0;
    scl_dr    = 1'b0;
    sda_dr    = 1'b0;
    errors    = 0;
  endfunction

  function int phase_count();
    case (op)
      OP_WRITE: return int'(WRITE_PHASES);
      OP_READ:  return int'(READ_PHASES);
      default:  return int'(EDGE_PHASES);
    endcase
  endfunction

  // a zero register value holds each phase for one tick
  function logic [TICK_W-1:0] hold_len();
    return (phase_len == '0) ? 8'd1 : phase_len;
  endfunction

  function bit busy();
    return op != OP_IDLE;
  endfunction

  // true when the next tick ends the running command
  function bit finishing();
    return busy() && (ticks >= hold_len()) && (int'(phase) + 1 >= phase_count());
  endfunction

  function void enter_phase(logic sda);
    int sub;
    case (op)
      OP_START: begin
        if (phase == 0) begin
          scl_dr = 1'b0;
          sda_dr = 1'b0;
        end else if (phase == 1) begin
          sda_dr = 1'b1;
        end else begin
          scl_dr = 1'b1;
        end
      end
      OP_STOP: begin
        if (phase == 0) sda_dr = 1'b1;
        else if (phase == 1) scl_dr = 1'b0;
        else sda_dr = 1'b0;
      end
      OP_WRITE: begin
        if (phase < WRITE_BIT_PHASES) begin
          sub = int'(phase) % 3;
          if (sub == SUB_DATA) begin
            sda_dr = ~shreg[BYTE_W-1];
          end else if (sub == SUB_SCL_HI) begin
            scl_dr = 1'b0;
          end else begin
            scl_dr = 1'b1;
            shreg  = {shreg[BYTE_W-2:0], 1'b0};
          end
        end else if (phase == WRITE_ACK_SDA) begin
          sda_dr = 1'b0;
        end else if (phase == WRITE_ACK_SCL) begin
          scl_dr = 1'b0;
        end else begin
          // sample the acknowledge as the clock goes low again
          ack_flag = (sda == 1'b0);
          scl_dr   = 1'b1;
        end
      end
      OP_READ: begin
        if (phase == 0) begin
          sda_dr = 1'b0;
        end else if (phase <= READ_LAST_BIT) begin
          if (phase[0]) begin
            scl_dr = 1'b0;
          end else begin
            shreg  = {shreg[BYTE_W-2:0], sda};
            scl_dr = 1'b1;
          end
        end else if (phase == READ_ACK_SDA) begin
          // during a read ack_flag holds last_read: release for no-acknowledge
          sda_dr = ack_flag ? 1'b0 : 1'b1;
        end else if (phase == READ_ACK_SCL_HI) begin
          scl_dr = 1'b0;
        end else if (phase == READ_ACK_SCL_LO) begin
          scl_dr = 1'b1;
        end else begin
          sda_dr = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_tick(in_t x);
    out_t due;
    bit   is_cmd;
    due    = '0;
    is_cmd = (x.kind >= OP_START) && (x.kind <= OP_READ);
    if (op == OP_IDLE) begin
      if (is_cmd) begin
        op    = op_t'(x.kind);
        phase = '0;
        ticks = 8'd1;
        if (op == OP_WRITE) begin
          shreg    = x.write_data;
          ack_flag = 1'b0;
        end else if (op == OP_READ) begin
          shreg    = '0;
          ack_flag = x.last_read;
        end
        enter_phase(x.sda_in);
      end
    end else begin
      due.rejected = is_cmd;
      if (ticks >= hold_len()) begin
        if (int'(phase) + 1 >= phase_count()) begin
          due.done_res = 1'b1;
          if (op == OP_WRITE) due.acked = ack_flag;
          else if (op == OP_READ) due.read_byte = shreg;
          op    = OP_IDLE;
          phase = '0;
          ticks = '0;
        end else begin
          phase = phase + 5'd1;
          ticks = 8'd1;
          enter_phase(x.sda_in);
        end
      end else begin
        ticks = ticks + 8'd1;
      end
    end
    due.scl_pull_low = scl_dr;
    due.sda_pull_low = sda_dr;
    due.busy_res     = busy();
    line_states_due.push_back(due);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_line_state(out_t got);
    out_t want;
    if (line_states_due.size() == 0) begin
      $display("%0t: result with nothing due, expected none, actual 0x%0h", $time, got);
      errors++;
      return;
    end
    want = line_states_due.pop_front();
    compare_field("scl_pull_low", 32'(want.scl_pull_low), 32'(got.scl_pull_low));
    compare_field("sda_pull_low", 32'(want.sda_pull_low), 32'(got.sda_pull_low));
    compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
    compare_field("acked", 32'(want.acked), 32'(got.acked));
    compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
    compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 200_000;
  localparam logic [APB_ADDR_W-1:0] ADDR_PHASE_TICKS = {CFG_IDX_PHASE_TICKS, 2'b00};
  localparam logic [2:0] KIND_UNUSED_MIN = 3'd5;
  localparam logic [2:0] KIND_MAX        = 3'd7;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  push    = 1'b0;
  in_t                   item    = '0;
  logic                  pop     = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic                  full;
  logic                  empty;
  out_t                  result;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  line_scoreboard sb;
  int send_idle_pct = 28;
  int recv_idle_pct = 66;

  i2c_open_drain_byte_master u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_line_state(result);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  function automatic logic sda_level(sda_mode_t mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  function automatic in_t idle_tick(sda_mode_t mode);
    in_t t;
    t.kind       = ($urandom_range(3) == 0) ?
                   3'($urandom_range(KIND_UNUSED_MIN, KIND_MAX)) : OP_IDLE;
    t.write_data = 8'($urandom);
    t.last_read  = 1'($urandom);
    t.sda_in     = sda_level(mode);
    return t;
  endfunction

  task automatic send_item(input in_t x);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    item <= x;
    do @(posedge clk); while (full);
    sb.note_tick(x);
    @(negedge clk);
  endtask

  // issue one command, then tick until it completes
  task automatic run_cmd(input op_t cmd, input logic [BYTE_W-1:0] data, input logic last,
                         input sda_mode_t mode, input int noise_pct, input bit hit_done);
    in_t t;
    t.kind       = cmd;
    t.write_data = data;
    t.last_read  = last;
    t.sda_in     = sda_level(mode);
    send_item(t);
    while (sb.busy()) begin
      t = idle_tick(mode);
      if (hit_done && sb.finishing()) t.kind = 3'($urandom_range(OP_START, OP_READ));
      else if ($urandom_range(99) < noise_pct) t.kind = 3'($urandom_range(OP_START, KIND_MAX));
      send_item(t);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.line_states_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_PHASE_TICKS;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_hold(input logic [TICK_W-1:0] want);
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd[TICK_W-1:0] !== want) begin
      $display("%0t: phase_ticks readback, expected 0x%0h, actual 0x%0h", $time, want,
               rd[TICK_W-1:0]);
      sb.errors++;
    end
  endtask

  task automatic set_hold(input logic [TICK_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b1, APB_DATA_W'(value), rd);
    sb.phase_len = value;
    check_hold(value);
  endtask

  task automatic directed_pass();
    in_t t;
    int  k;
    t = idle_tick(SDA_RAND);
    t.kind = OP_IDLE;
    send_item(t);
    for (k = int'(KIND_UNUSED_MIN); k <= int'(KIND_MAX); k++) begin
      t.kind = 3'(k);
      send_item(t);
    end
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 0, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b0, SDA_LOW, 0, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0, 1'b0);
    // commands land mid-transfer and on the done tick
    run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 30, 1'b1);
    run_cmd(OP_READ, 8'h5A, 1'b0, SDA_HIGH, 0, 1'b0);
    run_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW, 0, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b0, SDA_RAND, 30, 1'b1);
    run_cmd(OP_START, 8'hFF, 1'b1, SDA_RAND, 0, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 0, 1'b0);
  endtask

  // mostly start, a few bytes, stop; some stray commands and missing stops
  task automatic random_transfers(input int n_cmds);
    int issued;
    int nbytes;
    issued = 0;
    while (issued < n_cmds) begin
      if ($urandom_range(99) < 80) begin
        run_cmd(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 4, $urandom_range(7) == 0);
        nbytes = $urandom_range(1, 3);
        repeat (nbytes) begin
          run_cmd($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom), 1'($urandom),
                  SDA_RAND, 4, $urandom_range(7) == 0);
        end
        if ($urandom_range(9) != 0)
          run_cmd(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 4, $urandom_range(7) == 0);
        issued += nbytes + 2;
      end else begin
        run_cmd(op_t'($urandom_range(OP_START, OP_READ)), 8'($urandom), 1'($urandom),
                SDA_RAND, 10, $urandom_range(3) == 0);
        issued++;
      end
      repeat ($urandom_range(0, 3)) send_item(idle_tick(SDA_RAND));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_hold(PHASE_TICKS_RESET);

    set_hold(8'd1);
    directed_pass();
    drain();

    set_hold(8'd0);
    random_transfers(3);
    drain();

    // longest phase: register path and plain ticks only
    set_hold(8'd255);
    repeat (4) send_item(idle_tick(SDA_RAND));
    drain();

    send_idle_pct = 66;
    recv_idle_pct = 28;
    set_hold(8'($urandom_range(2, 3)));
    random_transfers(2);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_hold(8'd1);
    random_transfers(3);
    drain();

    if (sb.errors == 0 && sb.line_states_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
